// ----- src/crsi_pkg.sv -----
// Shared types, widths and codes for the ray/segment versus circle intersection core.
package crsi_pkg;

	// Coordinate format
	localparam int CW = 32;                // coordinate width, signed
	localparam int FB = 16;                // fraction bits
	localparam int CFG_W = 32;             // config write data width
	localparam int CFG_IDX_W = 2;          // config register index width

	// Internal value bound: magnitudes saturate at 2^IW - 1
	localparam int IW = 62;

	// Segment length path
	localparam int VMW = CW + 1;           // magnitude of a coordinate difference
	localparam int LRAD_W = 2 * VMW;       // vx^2 + vy^2
	localparam int LEN_W = LRAD_W / 2;     // segment length (floor sqrt)
	localparam int Q_W = FB + 1;           // unit direction quotient

	// Quadratic path
	localparam int UM_W = CW;              // magnitude of a direction component
	localparam int PUD_W = UM_W + VMW;     // dir * diff product
	localparam int PDD_W = 2 * VMW;        // diff * diff product
	localparam int PRR_W = 2 * (CW - 1);   // radius squared
	localparam int DOT_W = 2 * CW - FB + 3;
	localparam int DM_W = DOT_W - 1;
	localparam int DLO_W = (DM_W + 1) / 2;
	localparam int DHI_W = DM_W - DLO_W;
	localparam int SQ_W = 2 * DM_W;
	localparam int DISC_W = IW + 2;
	localparam int DRAD_W = IW + FB;       // discriminant scaled for the root
	localparam int DRT_W = DRAD_W / 2;
	localparam int T_W = DOT_W + 1;

	localparam logic [IW-1:0] IMAX = {IW{1'b1}};

	// Input function codes
	localparam logic FUNC_RAY = 1'b0;
	localparam logic FUNC_SEG = 1'b1;

	// Config register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EPSILON  = 2'd3;

	// Query beat
	typedef struct packed {
		logic                 func;
		logic signed [CW-1:0] start_x;
		logic signed [CW-1:0] start_y;
		logic signed [CW-1:0] second_x;
		logic signed [CW-1:0] second_y;
	} in_t;

	// Result beat
	typedef struct packed {
		logic                 hit;
		logic                 first_valid;
		logic signed [CW-1:0] first_distance;
		logic                 second_valid;
		logic signed [CW-1:0] second_distance;
		logic                 saturated;
	} out_t;

	// Payload carried through the length root
	typedef struct packed {
		in_t            q;
		logic [VMW-1:0] vxm;
		logic [VMW-1:0] vym;
		logic           vxn;
		logic           vyn;
	} lpl_t;

	// One step of the length root
	typedef struct packed {
		logic [LRAD_W-1:0] rad;
		logic [LEN_W+1:0]  rem;
		logic [LEN_W-1:0]  root;
	} lsq_t;

	// Payload carried through the unit direction divide
	typedef struct packed {
		in_t              q;
		logic             vxn;
		logic             vyn;
		logic [LEN_W-1:0] len;
	} dpl_t;

	// One step of the unit direction divide
	typedef struct packed {
		logic [LEN_W:0] rx;
		logic [LEN_W:0] ry;
		logic [Q_W-1:0] qx;
		logic [Q_W-1:0] qy;
	} dv_t;

	// Payload carried through the discriminant root
	typedef struct packed {
		logic signed [DOT_W-1:0] dot;
		logic [LEN_W-1:0]        len;
		logic                    seg;
		logic                    neg;
		logic                    tang;
		logic                    sat;
	} rpl_t;

	// One step of the discriminant root
	typedef struct packed {
		logic [DRAD_W-1:0] rad;
		logic [DRT_W+1:0]  rem;
		logic [DRT_W-1:0]  root;
	} dsq_t;

endpackage

// ----- src/circle_ray_segment_intersect_core.sv -----
// Ray/segment versus circle intersection core: fully pipelined top level.
// Pipeline from the start beat to the done strobe: 3 front stages, 33 length-root steps,
// 17 divide steps, 39 root steps and 10 quadratic stages (s4 to s11 before the root, s12 and s13 after it).
// Throughput: one query per cycle; busy stays low, every stage advances each cycle.
// Reset clears the valid bits of all stages and the config registers to zero.
// Config is taken on cfg_we and must only change while no query is in flight.
module circle_ray_segment_intersect_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  crsi_pkg::in_t                      query,
	output logic                               done,
	output crsi_pkg::out_t                     result,
	input  logic                               cfg_we,
	input  logic [crsi_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [crsi_pkg::CFG_W-1:0]         cfg_wdata
);

	localparam int CW     = crsi_pkg::CW;
	localparam int FB     = crsi_pkg::FB;
	localparam int IW     = crsi_pkg::IW;
	localparam int VMW    = crsi_pkg::VMW;
	localparam int LRAD_W = crsi_pkg::LRAD_W;
	localparam int LEN_W  = crsi_pkg::LEN_W;
	localparam int Q_W    = crsi_pkg::Q_W;
	localparam int UM_W   = crsi_pkg::UM_W;
	localparam int PUD_W  = crsi_pkg::PUD_W;
	localparam int PDD_W  = crsi_pkg::PDD_W;
	localparam int PRR_W  = crsi_pkg::PRR_W;
	localparam int DOT_W  = crsi_pkg::DOT_W;
	localparam int DM_W   = crsi_pkg::DM_W;
	localparam int DLO_W  = crsi_pkg::DLO_W;
	localparam int DHI_W  = crsi_pkg::DHI_W;
	localparam int SQ_W   = crsi_pkg::SQ_W;
	localparam int DISC_W = crsi_pkg::DISC_W;
	localparam int DRAD_W = crsi_pkg::DRAD_W;
	localparam int DRT_W  = crsi_pkg::DRT_W;
	localparam int T_W    = crsi_pkg::T_W;

	// clamp to the signed coordinate range; top bit flags an overflow
	function automatic logic [CW:0] clamp_t(input logic signed [T_W-1:0] t);
		logic [T_W-CW:0] top;
		logic            ovf;
		logic [CW-1:0]   val;
		top = t[T_W-1:CW-1];
		ovf = !((&top) || (~|top));
		if (!ovf) begin
			val = t[CW-1:0];
		end else if (t[T_W-1]) begin
			val = {1'b1, {(CW-1){1'b0}}};
		end else begin
			val = {1'b0, {(CW-1){1'b1}}};
		end
		return {ovf, val};
	endfunction

	// ---------------------------------------------------------------
	// Config registers
	logic signed [CW-1:0] cx_q, cy_q;
	logic [CW-2:0]        rad_q;
	logic [31:0]          eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q  <= '0;
			cy_q  <= '0;
			rad_q <= '0;
			eps_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				crsi_pkg::CFG_CENTER_X: cx_q  <= cfg_wdata[CW-1:0];
				crsi_pkg::CFG_CENTER_Y: cy_q  <= cfg_wdata[CW-1:0];
				crsi_pkg::CFG_RADIUS:   rad_q <= cfg_wdata[CW-2:0];
				crsi_pkg::CFG_EPSILON:  eps_q <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	// every stage advances each cycle
	assign busy = 1'b0;

	// ---------------------------------------------------------------
	// s1: capture beat, segment vector magnitudes
	logic           v_s1;
	crsi_pkg::lpl_t pl_s1;
	logic signed [VMW-1:0] vx_c, vy_c;

	always_comb begin
		vx_c = VMW'(query.second_x) - VMW'(query.start_x);
		vy_c = VMW'(query.second_y) - VMW'(query.start_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= start;
	end

	always_ff @(posedge clk) begin
		pl_s1.q   <= query;
		pl_s1.vxn <= vx_c[VMW-1];
		pl_s1.vyn <= vy_c[VMW-1];
		pl_s1.vxm <= vx_c[VMW-1] ? VMW'(-vx_c) : VMW'(vx_c);
		pl_s1.vym <= vy_c[VMW-1] ? VMW'(-vy_c) : VMW'(vy_c);
	end

	// s2: squares of the vector components
	logic              v_s2;
	crsi_pkg::lpl_t    pl_s2;
	logic [LRAD_W-1:0] vxsq_s2, vysq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		pl_s2   <= pl_s1;
		vxsq_s2 <= pl_s1.vxm * pl_s1.vxm;
		vysq_s2 <= pl_s1.vym * pl_s1.vym;
	end

	// s3: squared length
	logic              v_s3;
	crsi_pkg::lpl_t    pl_s3;
	logic [LRAD_W-1:0] lsum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		pl_s3   <= pl_s2;
		lsum_s3 <= vxsq_s2 + vysq_s2;
	end

	// ---------------------------------------------------------------
	// Length root: one result bit per stage
	logic           lv_s  [LEN_W];
	crsi_pkg::lpl_t lpl_s [LEN_W];
	crsi_pkg::lsq_t lsq_s [LEN_W];

	for (genvar k = 0; k < LEN_W; k++) begin : g_lsq
		logic           v_in;
		crsi_pkg::lpl_t pl_in;
		crsi_pkg::lsq_t cur, nxt;
		logic [LEN_W+1:0] rsh, trial;

		if (k == 0) begin : g_first
			assign v_in  = v_s3;
			assign pl_in = pl_s3;
			assign cur   = '{rad: lsum_s3, rem: '0, root: '0};
		end else begin : g_next
			assign v_in  = lv_s[k-1];
			assign pl_in = lpl_s[k-1];
			assign cur   = lsq_s[k-1];
		end

		// trial subtract of (root<<2 | 1)
		always_comb begin
			rsh     = {cur.rem[LEN_W-1:0], cur.rad[LRAD_W-1 -: 2]};
			trial   = {cur.root, 2'b01};
			nxt.rad = cur.rad << 2;
			if (rsh >= trial) begin
				nxt.rem  = rsh - trial;
				nxt.root = {cur.root[LEN_W-2:0], 1'b1};
			end else begin
				nxt.rem  = rsh;
				nxt.root = {cur.root[LEN_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) lv_s[k] <= 1'b0;
			else         lv_s[k] <= v_in;
		end

		always_ff @(posedge clk) begin
			lpl_s[k] <= pl_in;
			lsq_s[k] <= nxt;
		end
	end

	// ---------------------------------------------------------------
	// Unit direction divide: |v| * 2^FB / len, one quotient bit per stage
	logic           dv_v_s [Q_W];
	crsi_pkg::dpl_t dpl_s  [Q_W];
	crsi_pkg::dv_t  dv_s   [Q_W];

	for (genvar j = 0; j < Q_W; j++) begin : g_div
		logic           v_in;
		crsi_pkg::dpl_t pl_in;
		crsi_pkg::dv_t  nxt;
		logic [LEN_W:0] rxs, rys, lenx;
		logic           bx, by;

		if (j == 0) begin : g_first
			assign v_in      = lv_s[LEN_W-1];
			assign pl_in.q   = lpl_s[LEN_W-1].q;
			assign pl_in.vxn = lpl_s[LEN_W-1].vxn;
			assign pl_in.vyn = lpl_s[LEN_W-1].vyn;
			assign pl_in.len = lsq_s[LEN_W-1].root;
			assign rxs       = (LEN_W+1)'(lpl_s[LEN_W-1].vxm);
			assign rys       = (LEN_W+1)'(lpl_s[LEN_W-1].vym);
			assign lenx      = (LEN_W+1)'(lsq_s[LEN_W-1].root);

			// integer step: the magnitude never exceeds the length
			always_comb begin
				bx = rxs >= lenx;
				by = rys >= lenx;
				nxt.rx = bx ? rxs - lenx : rxs;
				nxt.ry = by ? rys - lenx : rys;
				nxt.qx = Q_W'(bx);
				nxt.qy = Q_W'(by);
			end
		end else begin : g_next
			assign v_in  = dv_v_s[j-1];
			assign pl_in = dpl_s[j-1];
			assign rxs   = {dv_s[j-1].rx[LEN_W-1:0], 1'b0};
			assign rys   = {dv_s[j-1].ry[LEN_W-1:0], 1'b0};
			assign lenx  = (LEN_W+1)'(dpl_s[j-1].len);

			// fraction step
			always_comb begin
				bx = rxs >= lenx;
				by = rys >= lenx;
				nxt.rx = bx ? rxs - lenx : rxs;
				nxt.ry = by ? rys - lenx : rys;
				nxt.qx = {dv_s[j-1].qx[Q_W-2:0], bx};
				nxt.qy = {dv_s[j-1].qy[Q_W-2:0], by};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[j] <= 1'b0;
			else         dv_v_s[j] <= v_in;
		end

		always_ff @(posedge clk) begin
			dpl_s[j] <= pl_in;
			dv_s[j]  <= nxt;
		end
	end

	// ---------------------------------------------------------------
	// s4: pick direction, offset from center, magnitudes and signs
	crsi_pkg::dpl_t        dq;
	crsi_pkg::dv_t         dd;
	logic                  dseg, dzero;
	logic signed [VMW-1:0] dx_c, dy_c;

	logic             v_s4, seg_s4;
	logic [LEN_W-1:0] len_s4;
	logic [UM_W-1:0]  uxm_s4, uym_s4;
	logic             uxn_s4, uyn_s4;
	logic [VMW-1:0]   dxm_s4, dym_s4;
	logic             dxn_s4, dyn_s4;

	always_comb begin
		dq    = dpl_s[Q_W-1];
		dd    = dv_s[Q_W-1];
		dseg  = dq.q.func == crsi_pkg::FUNC_SEG;
		dzero = ~|dq.len;
		dx_c  = VMW'(dq.q.start_x) - VMW'(cx_q);
		dy_c  = VMW'(dq.q.start_y) - VMW'(cy_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else         v_s4 <= dv_v_s[Q_W-1];
	end

	always_ff @(posedge clk) begin
		seg_s4 <= dseg;
		len_s4 <= dq.len;
		if (dseg) begin
			uxm_s4 <= dzero ? '0 : UM_W'(dd.qx);
			uym_s4 <= dzero ? '0 : UM_W'(dd.qy);
			uxn_s4 <= dq.vxn;
			uyn_s4 <= dq.vyn;
		end else begin
			uxm_s4 <= dq.q.second_x[CW-1] ? UM_W'(-dq.q.second_x) : UM_W'(dq.q.second_x);
			uym_s4 <= dq.q.second_y[CW-1] ? UM_W'(-dq.q.second_y) : UM_W'(dq.q.second_y);
			uxn_s4 <= dq.q.second_x[CW-1];
			uyn_s4 <= dq.q.second_y[CW-1];
		end
		dxm_s4 <= dx_c[VMW-1] ? VMW'(-dx_c) : VMW'(dx_c);
		dym_s4 <= dy_c[VMW-1] ? VMW'(-dy_c) : VMW'(dy_c);
		dxn_s4 <= dx_c[VMW-1];
		dyn_s4 <= dy_c[VMW-1];
	end

	// s5: products
	logic             v_s5, seg_s5, sgx_s5, sgy_s5;
	logic [LEN_W-1:0] len_s5;
	logic [PUD_W-1:0] pudx_s5, pudy_s5;
	logic [PDD_W-1:0] pddx_s5, pddy_s5;
	logic [PRR_W-1:0] prr_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else         v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		seg_s5  <= seg_s4;
		len_s5  <= len_s4;
		sgx_s5  <= uxn_s4 ^ dxn_s4;
		sgy_s5  <= uyn_s4 ^ dyn_s4;
		pudx_s5 <= uxm_s4 * dxm_s4;
		pudy_s5 <= uym_s4 * dym_s4;
		pddx_s5 <= dxm_s4 * dxm_s4;
		pddy_s5 <= dym_s4 * dym_s4;
		prr_s5  <= rad_q * rad_q;
	end

	// s6: dot = dir . d, e = |d|^2 - r^2
	logic signed [DOT_W-1:0] tx_c, ty_c, dot_c, e_c;

	logic                    v_s6, seg_s6;
	logic [LEN_W-1:0]        len_s6;
	logic signed [DOT_W-1:0] dot_s6, e_s6;

	always_comb begin
		tx_c  = DOT_W'(pudx_s5 >> FB);
		ty_c  = DOT_W'(pudy_s5 >> FB);
		if (sgx_s5) tx_c = -tx_c;
		if (sgy_s5) ty_c = -ty_c;
		dot_c = tx_c + ty_c;
		e_c   = DOT_W'(pddx_s5 >> FB) + DOT_W'(pddy_s5 >> FB) - DOT_W'(prr_s5 >> FB);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else         v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		seg_s6 <= seg_s5;
		len_s6 <= len_s5;
		dot_s6 <= dot_c;
		e_s6   <= e_c;
	end

	// s7: |dot|
	logic                    v_s7, seg_s7;
	logic [LEN_W-1:0]        len_s7;
	logic signed [DOT_W-1:0] dot_s7, e_s7;
	logic [DM_W-1:0]         dotm_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else         v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		seg_s7  <= seg_s6;
		len_s7  <= len_s6;
		dot_s7  <= dot_s6;
		e_s7    <= e_s6;
		dotm_s7 <= dot_s6[DOT_W-1] ? DM_W'(-dot_s6) : DM_W'(dot_s6);
	end

	// s8: dot^2 as three partial products
	logic                    v_s8, seg_s8;
	logic [LEN_W-1:0]        len_s8;
	logic signed [DOT_W-1:0] dot_s8, e_s8;
	logic [2*DHI_W-1:0]      pphh_s8;
	logic [DHI_W+DLO_W-1:0]  pphl_s8;
	logic [2*DLO_W-1:0]      ppll_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else         v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		seg_s8  <= seg_s7;
		len_s8  <= len_s7;
		dot_s8  <= dot_s7;
		e_s8    <= e_s7;
		pphh_s8 <= dotm_s7[DM_W-1:DLO_W] * dotm_s7[DM_W-1:DLO_W];
		pphl_s8 <= dotm_s7[DM_W-1:DLO_W] * dotm_s7[DLO_W-1:0];
		ppll_s8 <= dotm_s7[DLO_W-1:0] * dotm_s7[DLO_W-1:0];
	end

	// s9: assemble dot^2, scale and saturate
	logic [SQ_W-1:0] sq_c;
	logic            sqsat_c;

	logic                    v_s9, seg_s9, sat_s9;
	logic [LEN_W-1:0]        len_s9;
	logic signed [DOT_W-1:0] dot_s9, e_s9;
	logic [IW-1:0]           dsq_s9;

	always_comb begin
		sq_c = (SQ_W'(pphh_s8) << (2 * DLO_W)) + (SQ_W'(pphl_s8) << (DLO_W + 1))
			+ SQ_W'(ppll_s8);
		sqsat_c = |sq_c[SQ_W-1:IW+FB];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else         v_s9 <= v_s8;
	end

	always_ff @(posedge clk) begin
		seg_s9 <= seg_s8;
		len_s9 <= len_s8;
		dot_s9 <= dot_s8;
		e_s9   <= e_s8;
		sat_s9 <= sqsat_c;
		dsq_s9 <= sqsat_c ? crsi_pkg::IMAX : sq_c[IW+FB-1:FB];
	end

	// s10: discriminant with upper saturation
	logic signed [DISC_W-1:0] disc_c;
	logic                     dsat_c;

	logic                     v_s10, seg_s10, sat_s10;
	logic [LEN_W-1:0]         len_s10;
	logic signed [DOT_W-1:0]  dot_s10;
	logic signed [DISC_W-1:0] disc_s10;

	always_comb begin
		disc_c = $signed({2'b00, dsq_s9}) - DISC_W'(e_s9);
		dsat_c = !disc_c[DISC_W-1] && (|disc_c[DISC_W-2:IW]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s10 <= 1'b0;
		else         v_s10 <= v_s9;
	end

	always_ff @(posedge clk) begin
		seg_s10  <= seg_s9;
		len_s10  <= len_s9;
		dot_s10  <= dot_s9;
		sat_s10  <= sat_s9 | dsat_c;
		disc_s10 <= dsat_c ? DISC_W'(crsi_pkg::IMAX) : disc_c;
	end

	// s11: miss / tangent classification, root radicand
	logic              v_s11;
	crsi_pkg::rpl_t    rpl_s11;
	logic [DRAD_W-1:0] drad_s11;
	logic              dneg_c;

	assign dneg_c = disc_s10[DISC_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s11 <= 1'b0;
		else         v_s11 <= v_s10;
	end

	always_ff @(posedge clk) begin
		rpl_s11.dot  <= dot_s10;
		rpl_s11.len  <= len_s10;
		rpl_s11.seg  <= seg_s10;
		rpl_s11.sat  <= sat_s10;
		rpl_s11.neg  <= dneg_c;
		rpl_s11.tang <= !dneg_c && (disc_s10[IW-1:0] <= IW'(eps_q));
		drad_s11     <= {disc_s10[IW-1:0], {FB{1'b0}}};
	end

	// ---------------------------------------------------------------
	// Discriminant root: one result bit per stage
	logic           rv_s  [DRT_W];
	crsi_pkg::rpl_t rpl_s [DRT_W];
	crsi_pkg::dsq_t dsq_s [DRT_W];

	for (genvar k = 0; k < DRT_W; k++) begin : g_dsq
		logic           v_in;
		crsi_pkg::rpl_t pl_in;
		crsi_pkg::dsq_t cur, nxt;
		logic [DRT_W+1:0] rsh, trial;

		if (k == 0) begin : g_first
			assign v_in  = v_s11;
			assign pl_in = rpl_s11;
			assign cur   = '{rad: drad_s11, rem: '0, root: '0};
		end else begin : g_next
			assign v_in  = rv_s[k-1];
			assign pl_in = rpl_s[k-1];
			assign cur   = dsq_s[k-1];
		end

		// trial subtract of (root<<2 | 1)
		always_comb begin
			rsh     = {cur.rem[DRT_W-1:0], cur.rad[DRAD_W-1 -: 2]};
			trial   = {cur.root, 2'b01};
			nxt.rad = cur.rad << 2;
			if (rsh >= trial) begin
				nxt.rem  = rsh - trial;
				nxt.root = {cur.root[DRT_W-2:0], 1'b1};
			end else begin
				nxt.rem  = rsh;
				nxt.root = {cur.root[DRT_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rv_s[k] <= 1'b0;
			else         rv_s[k] <= v_in;
		end

		always_ff @(posedge clk) begin
			rpl_s[k] <= pl_in;
			dsq_s[k] <= nxt;
		end
	end

	// ---------------------------------------------------------------
	// s12: roots -dot + s and -dot - s
	crsi_pkg::rpl_t      rp;
	logic signed [T_W-1:0] ndot_c, s_c;

	logic                  v_s12, seg_s12, sat_s12, v0_s12, v1_s12;
	logic [LEN_W-1:0]      len_s12;
	logic signed [T_W-1:0] t0_s12, t1_s12;

	always_comb begin
		rp     = rpl_s[DRT_W-1];
		ndot_c = -T_W'(rp.dot);
		s_c    = $signed(T_W'(dsq_s[DRT_W-1].root));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s12 <= 1'b0;
		else         v_s12 <= rv_s[DRT_W-1];
	end

	always_ff @(posedge clk) begin
		seg_s12 <= rp.seg;
		sat_s12 <= rp.sat;
		len_s12 <= rp.len;
		v0_s12  <= !rp.neg;
		v1_s12  <= !rp.neg && !rp.tang;
		t0_s12  <= rp.tang ? ndot_c : ndot_c + s_c;
		t1_s12  <= ndot_c - s_c;
	end

	// s13: range filter for segments, slot packing, clamp
	logic          k0_c, k1_c;
	logic [CW:0]   c0_c, c1_c;
	crsi_pkg::out_t res_c;

	logic           v_s13;
	crsi_pkg::out_t res_s13;

	always_comb begin
		k0_c = v0_s12 && !(seg_s12 && (t0_s12[T_W-1] ||
			(t0_s12[T_W-2:0] > (T_W-1)'(len_s12))));
		k1_c = v1_s12 && !(seg_s12 && (t1_s12[T_W-1] ||
			(t1_s12[T_W-2:0] > (T_W-1)'(len_s12))));
		c0_c = clamp_t(t0_s12);
		c1_c = clamp_t(t1_s12);

		res_c.hit             = k0_c | k1_c;
		res_c.first_valid     = k0_c | k1_c;
		res_c.first_distance  = k0_c ? c0_c[CW-1:0] : (k1_c ? c1_c[CW-1:0] : '0);
		res_c.second_valid    = k0_c & k1_c;
		res_c.second_distance = (k0_c & k1_c) ? c1_c[CW-1:0] : '0;
		res_c.saturated       = sat_s12 | (k0_c & c0_c[CW]) | (k1_c & c1_c[CW]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s13 <= 1'b0;
		else         v_s13 <= v_s12;
	end

	always_ff @(posedge clk) begin
		res_s13 <= res_c;
	end

	assign done   = v_s13;
	assign result = res_s13;

endmodule
